// ----- design/three_phase_current_to_dq_core_macros.svh -----
// Assertion macros used by the pipeline control of the three-phase current to d/q block
`ifndef THREE_PHASE_CURRENT_TO_DQ_CORE_MACROS_SVH
`define THREE_PHASE_CURRENT_TO_DQ_CORE_MACROS_SVH

// Same-cycle implication, checked while out of reset
`define TPCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tpcd: same-cycle check failed");

// Next-cycle implication, checked while out of reset
`define TPCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tpcd: next-cycle check failed");

`endif

// ----- design/tpcd_pkg.sv -----
// Package: constants, stage numbers and helpers for the current to d/q block
package tpcd_pkg;

    // Default widths of the ADC samples and of the angle
    localparam int ADC_BITS_DEF   = 12;
    localparam int ANGLE_BITS_DEF = 12;

    // Fixed result and register widths
    localparam int PHASE_W    = 13;
    localparam int DQ_W       = 14;
    localparam int POLE_W     = 7;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_ADC_MIDPOINT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_POLE_PAIRS   = 2'd1;

    localparam logic [POLE_W-1:0] POLE_PAIRS_RESET = 7'd7;

    // Pipeline stage numbers
    localparam int STAGES     = 9;
    localparam int ST_DIFF    = 1;
    localparam int ST_MIX     = 2;
    localparam int ST_POLY_T  = 3;
    localparam int ST_POLY_U  = 4;
    localparam int ST_POLY_S  = 5;
    localparam int ST_PROD    = 6;
    localparam int ST_SUM     = 7;
    localparam int ST_ROUND   = 8;
    localparam int ST_OUT     = 9;

    // Quadrant codes
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // Quarter-wave sine polynomial, Q16
    localparam logic [16:0] QS_ONE   = 17'h10000;
    localparam logic [16:0] POLY_A   = 17'd102944;
    localparam logic [15:0] POLY_B   = 16'd42048;
    localparam logic [12:0] POLY_C   = 13'd4640;
    localparam logic [14:0] SINE_MAX = 15'd32767;

    // sqrt(3) in Q1.15
    localparam logic [16:0] SQRT3_Q15 = 17'd56756;

    // Rounding divide by 3 * 2^30: bias is half the divisor
    localparam logic [31:0] ROUND_BIAS = 32'd1610612736;
    localparam logic [14:0] M_CLAMP    = 15'd24576;
    localparam logic [15:0] DIV3_RECIP = 16'd43691;
    localparam int          DIV3_SHIFT = 17;

    // Result limits
    localparam logic signed [PHASE_W-1:0] PHASE_MAX = 13'sd4095;
    localparam logic signed [PHASE_W-1:0] PHASE_MIN = -13'sd4096;
    localparam logic [DQ_W-1:0]           DQ_MAX    = 14'd8191;

    // Saturate a phase difference to the result range
    function automatic logic signed [PHASE_W-1:0] sat_phase(input logic signed [31:0] v);
        logic signed [PHASE_W-1:0] res;
        if (v > 32'(PHASE_MAX))
            res = PHASE_MAX;
        else if (v < 32'(PHASE_MIN))
            res = PHASE_MIN;
        else
            res = PHASE_W'(v);
        return res;
    endfunction

endpackage

// ----- design/tpcd_in_if.sv -----
// Input channel: raw phase samples and mechanical angle
interface tpcd_in_if #(
    parameter int ADC_BITS   = tpcd_pkg::ADC_BITS_DEF,
    parameter int ANGLE_BITS = tpcd_pkg::ANGLE_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [ADC_BITS-1:0]   sample_a;
    logic [ADC_BITS-1:0]   sample_b;
    logic [ADC_BITS-1:0]   sample_c;
    logic [ANGLE_BITS-1:0] mech_angle;

    modport source (output valid, sample_a, sample_b, sample_c, mech_angle, input ready);
    modport sink   (input valid, sample_a, sample_b, sample_c, mech_angle, output ready);
endinterface

// ----- design/tpcd_out_if.sv -----
// Output channel: phase currents and d/q currents
interface tpcd_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [tpcd_pkg::PHASE_W-1:0]  phase_a_amps;
    logic signed [tpcd_pkg::PHASE_W-1:0]  phase_b_amps;
    logic signed [tpcd_pkg::PHASE_W-1:0]  phase_c_amps;
    logic signed [tpcd_pkg::DQ_W-1:0]     direct_amps;
    logic signed [tpcd_pkg::DQ_W-1:0]     quadrature_amps;

    modport source (output valid, phase_a_amps, phase_b_amps, phase_c_amps,
                    direct_amps, quadrature_amps, input ready);
    modport sink   (input valid, phase_a_amps, phase_b_amps, phase_c_amps,
                    direct_amps, quadrature_amps, output ready);
endinterface

// ----- design/tpcd_cfg_if.sv -----
// Configuration write channel: register index and write data
interface tpcd_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [tpcd_pkg::CFG_ADDR_W-1:0]   index;
    logic [tpcd_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/tpcd_ctrl.sv -----
// Pipeline control: stage valid bits and per-stage load enables
`include "three_phase_current_to_dq_core_macros.svh"

module tpcd_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [tpcd_pkg::STAGES:1]   load
);

    logic [tpcd_pkg::STAGES:1]   vld_reg;
    logic [tpcd_pkg::STAGES:1]   vld_next;
    logic [tpcd_pkg::STAGES+1:1] rdy;
    logic [tpcd_pkg::STAGES:1]   vld_src;

    // A stage takes a new item when empty or when the next stage takes its own
    always_comb
    begin
        rdy[tpcd_pkg::STAGES+1] = out_ready;
        for (int k = tpcd_pkg::STAGES; k >= 1; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign vld_src = {vld_reg[tpcd_pkg::STAGES-1:1], in_valid};

    always_comb
    begin
        for (int k = 1; k <= tpcd_pkg::STAGES; k++)
        begin
            vld_next[k] = rdy[k] ? vld_src[k] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign load      = rdy[tpcd_pkg::STAGES:1];
    assign in_ready  = rdy[1];
    assign out_valid = vld_reg[tpcd_pkg::STAGES];

    // An accepted item lands in the first stage
    `TPCD_ASSERT_NEXT(a_accept_fills, clk, rst_n, in_valid && in_ready, vld_reg[1])
    // A ready sink never blocks the input
    `TPCD_ASSERT_NOW(a_ready_through, clk, rst_n, out_ready, in_ready)
    // An empty output stage leaves room at the input
    `TPCD_ASSERT_NOW(a_bubble_ready, clk, rst_n, !out_valid, in_ready)

endmodule

// ----- design/tpcd_front.sv -----
// Front end: midpoint removal, electrical angle, Clarke sums, phase saturation
module tpcd_front #(
    parameter int ADC_BITS   = tpcd_pkg::ADC_BITS_DEF,
    parameter int ANGLE_BITS = tpcd_pkg::ANGLE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic [tpcd_pkg::STAGES:1]             load,
    input  logic [ADC_BITS-1:0]                   sample_a,
    input  logic [ADC_BITS-1:0]                   sample_b,
    input  logic [ADC_BITS-1:0]                   sample_c,
    input  logic [ANGLE_BITS-1:0]                 mech_angle,
    input  logic [ADC_BITS-1:0]                   midpoint,
    input  logic [tpcd_pkg::POLE_W-1:0]           pole_pairs,
    output logic [16:0]                           x_sin,
    output logic [16:0]                           x_cos,
    output logic [1:0]                            quad,
    output logic signed [ADC_BITS+2:0]            asum,
    output logic signed [ADC_BITS+1:0]            bmc,
    output logic signed [tpcd_pkg::PHASE_W-1:0]   pa,
    output logic signed [tpcd_pkg::PHASE_W-1:0]   pb,
    output logic signed [tpcd_pkg::PHASE_W-1:0]   pc
);

    localparam int DW = ADC_BITS + 1;
    localparam int AW = ADC_BITS + 3;
    localparam int BW = ADC_BITS + 2;
    localparam int EW = ANGLE_BITS + tpcd_pkg::POLE_W;
    localparam int FW = ANGLE_BITS - 2;
    localparam int XS = 18 - ANGLE_BITS;

    logic [EW-1:0]          e_prod;
    logic [ANGLE_BITS-1:0]  e_angle;
    logic [16:0]            x_next;
    logic signed [DW-1:0]   da_next, db_next, dc_next;

    logic signed [DW-1:0]   da_reg, db_reg, dc_reg;
    logic [16:0]            xs_reg, xc_reg;
    logic [1:0]             quad1_reg, quad2_reg;
    logic signed [AW-1:0]   asum_reg;
    logic signed [BW-1:0]   bmc_reg;
    logic signed [tpcd_pkg::PHASE_W-1:0] pa_reg, pb_reg, pc_reg;

    // Stage 1: subtract midpoint, electrical angle wrapped to one turn
    assign da_next = $signed({1'b0, sample_a}) - $signed({1'b0, midpoint});
    assign db_next = $signed({1'b0, sample_b}) - $signed({1'b0, midpoint});
    assign dc_next = $signed({1'b0, sample_c}) - $signed({1'b0, midpoint});
    assign e_prod  = EW'(mech_angle) * EW'(pole_pairs);
    assign e_angle = e_prod[ANGLE_BITS-1:0];
    assign x_next  = 17'({e_angle[FW-1:0], {XS{1'b0}}});

    always_ff @(posedge clk)
    begin
        if (load[tpcd_pkg::ST_DIFF])
        begin
            da_reg    <= da_next;
            db_reg    <= db_next;
            dc_reg    <= dc_next;
            quad1_reg <= e_angle[ANGLE_BITS-1 -: 2];
            xs_reg    <= x_next;
            xc_reg    <= tpcd_pkg::QS_ONE - x_next;
        end
    end

    // Stage 2: 2a - b - c and b - c, saturated phase outputs
    always_ff @(posedge clk)
    begin
        if (load[tpcd_pkg::ST_MIX])
        begin
            asum_reg  <= (AW'(da_reg) <<< 1) - AW'(db_reg) - AW'(dc_reg);
            bmc_reg   <= BW'(db_reg) - BW'(dc_reg);
            quad2_reg <= quad1_reg;
            pa_reg    <= tpcd_pkg::sat_phase(32'(da_reg));
            pb_reg    <= tpcd_pkg::sat_phase(32'(db_reg));
            pc_reg    <= tpcd_pkg::sat_phase(32'(dc_reg));
        end
    end

    assign x_sin = xs_reg;
    assign x_cos = xc_reg;
    assign quad  = quad2_reg;
    assign asum  = asum_reg;
    assign bmc   = bmc_reg;
    assign pa    = pa_reg;
    assign pb    = pb_reg;
    assign pc    = pc_reg;

endmodule

// ----- design/tpcd_qsine.sv -----
// Quarter-wave sine: four-stage polynomial pipeline, Q0.16 in, Q1.15 out
module tpcd_qsine (
    input  logic                      clk,
    input  logic [tpcd_pkg::STAGES:1] load,
    input  logic [16:0]               x,
    output logic [14:0]               sine
);

    logic [33:0] xx_prod;
    logic [29:0] cx2_prod;
    logic [32:0] x2t_prod;
    logic [33:0] xu_prod;
    logic [17:0] s_val;
    logic [17:0] r_val;

    logic [16:0] x2_reg, x2b_reg;
    logic [16:0] xa_reg, xb_reg, xc_reg;
    logic [15:0] t_reg;
    logic [16:0] u_reg;
    logic [14:0] r_reg;

    // Stage 2: x^2
    assign xx_prod = 34'(x) * 34'(x);

    always_ff @(posedge clk)
    begin
        if (load[tpcd_pkg::ST_MIX])
        begin
            x2_reg <= xx_prod[32:16];
            xa_reg <= x;
        end
    end

    // Stage 3: t = B - C*x^2
    assign cx2_prod = 30'(tpcd_pkg::POLY_C) * 30'(x2_reg);

    always_ff @(posedge clk)
    begin
        if (load[tpcd_pkg::ST_POLY_T])
        begin
            t_reg   <= tpcd_pkg::POLY_B - cx2_prod[29:16];
            x2b_reg <= x2_reg;
            xb_reg  <= xa_reg;
        end
    end

    // Stage 4: u = A - x^2*t
    assign x2t_prod = 33'(x2b_reg) * 33'(t_reg);

    always_ff @(posedge clk)
    begin
        if (load[tpcd_pkg::ST_POLY_U])
        begin
            u_reg  <= tpcd_pkg::POLY_A - x2t_prod[32:16];
            xc_reg <= xb_reg;
        end
    end

    // Stage 5: s = x*u, round Q16 to Q15, clamp
    assign xu_prod = 34'(xc_reg) * 34'(u_reg);
    assign s_val   = xu_prod[33:16];
    assign r_val   = (s_val + 18'd1) >> 1;

    always_ff @(posedge clk)
    begin
        if (load[tpcd_pkg::ST_POLY_S])
        begin
            if (r_val > 18'(tpcd_pkg::SINE_MAX))
                r_reg <= tpcd_pkg::SINE_MAX;
            else
                r_reg <= r_val[14:0];
        end
    end

    assign sine = r_reg;

endmodule

// ----- design/tpcd_proj.sv -----
// Park projection: quadrant select, products, rounding divide by 3, saturation
module tpcd_proj #(
    parameter int ADC_BITS = tpcd_pkg::ADC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic [tpcd_pkg::STAGES:1]             load,
    input  logic [1:0]                            quad,
    input  logic signed [ADC_BITS+2:0]            asum,
    input  logic signed [ADC_BITS+1:0]            bmc,
    input  logic signed [tpcd_pkg::PHASE_W-1:0]   pa,
    input  logic signed [tpcd_pkg::PHASE_W-1:0]   pb,
    input  logic signed [tpcd_pkg::PHASE_W-1:0]   pc,
    input  logic [14:0]                           sin_q,
    input  logic [14:0]                           cos_q,
    output logic signed [tpcd_pkg::PHASE_W-1:0]   pa_out,
    output logic signed [tpcd_pkg::PHASE_W-1:0]   pb_out,
    output logic signed [tpcd_pkg::PHASE_W-1:0]   pc_out,
    output logic signed [tpcd_pkg::DQ_W-1:0]      direct,
    output logic signed [tpcd_pkg::DQ_W-1:0]      quadrature
);

    localparam int AW  = ADC_BITS + 3;
    localparam int BW  = ADC_BITS + 2;
    localparam int PA  = 16 + AW;
    localparam int PB  = 16 + BW;
    localparam int D3W = ADC_BITS + 36;
    localparam int MW  = D3W - 29;
    localparam int PHW = tpcd_pkg::PHASE_W;
    localparam int SINE_DLY = tpcd_pkg::ST_POLY_S - tpcd_pkg::ST_MIX;
    localparam int PH_DLY   = tpcd_pkg::ST_OUT - tpcd_pkg::ST_MIX;

    // Delay lines that wait for the sine pipeline
    logic [1:0]           quad_d_reg [SINE_DLY];
    logic signed [AW-1:0] asum_d_reg [SINE_DLY];
    logic signed [BW-1:0] bmc_d_reg  [SINE_DLY];
    logic signed [PHW-1:0] pa_d_reg  [PH_DLY];
    logic signed [PHW-1:0] pb_d_reg  [PH_DLY];
    logic signed [PHW-1:0] pc_d_reg  [PH_DLY];

    logic signed [15:0]    sn, cs, sx, sc;
    logic signed [PA-1:0]  p_ca_reg, p_sa_reg;
    logic signed [PB-1:0]  p_cb_reg, p_sb_reg;
    logic signed [D3W-1:0] d3_next [2];
    logic signed [D3W-1:0] d3_reg  [2];
    logic [D3W-1:0]        mag     [2];
    logic [D3W:0]          biased  [2];
    logic [MW-1:0]         m_val   [2];
    logic [14:0]           mcl_reg [2];
    logic                  neg_reg [2];
    logic                  neg2_reg [2];
    logic [31:0]           rq_prod [2];
    logic [tpcd_pkg::DQ_W-1:0] rq  [2];
    logic signed [tpcd_pkg::DQ_W-1:0] dq_next [2];
    logic signed [tpcd_pkg::DQ_W-1:0] dq_reg  [2];

    // Stages 3 to 5: hold Clarke terms and quadrant
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < SINE_DLY; k++)
        begin
            if (load[tpcd_pkg::ST_POLY_T + k])
            begin
                if (k == 0)
                begin
                    quad_d_reg[k] <= quad;
                    asum_d_reg[k] <= asum;
                    bmc_d_reg[k]  <= bmc;
                end
                else
                begin
                    quad_d_reg[k] <= quad_d_reg[k-1];
                    asum_d_reg[k] <= asum_d_reg[k-1];
                    bmc_d_reg[k]  <= bmc_d_reg[k-1];
                end
            end
        end
    end

    // Stages 3 to 9: phase outputs ride along
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < PH_DLY; k++)
        begin
            if (load[tpcd_pkg::ST_POLY_T + k])
            begin
                if (k == 0)
                begin
                    pa_d_reg[k] <= pa;
                    pb_d_reg[k] <= pb;
                    pc_d_reg[k] <= pc;
                end
                else
                begin
                    pa_d_reg[k] <= pa_d_reg[k-1];
                    pb_d_reg[k] <= pb_d_reg[k-1];
                    pc_d_reg[k] <= pc_d_reg[k-1];
                end
            end
        end
    end

    // Stage 6: quadrant symmetry and the four products
    assign sx = $signed({1'b0, sin_q});
    assign sc = $signed({1'b0, cos_q});

    always_comb
    begin
        case (quad_d_reg[SINE_DLY-1])
            tpcd_pkg::QUAD_0:
            begin
                sn = sx;
                cs = sc;
            end
            tpcd_pkg::QUAD_1:
            begin
                sn = sc;
                cs = -sx;
            end
            tpcd_pkg::QUAD_2:
            begin
                sn = -sx;
                cs = -sc;
            end
            default:
            begin
                sn = -sc;
                cs = sx;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load[tpcd_pkg::ST_PROD])
        begin
            p_ca_reg <= PA'(cs) * PA'(asum_d_reg[SINE_DLY-1]);
            p_sa_reg <= PA'(sn) * PA'(asum_d_reg[SINE_DLY-1]);
            p_cb_reg <= PB'(cs) * PB'(bmc_d_reg[SINE_DLY-1]);
            p_sb_reg <= PB'(sn) * PB'(bmc_d_reg[SINE_DLY-1]);
        end
    end

    // Stage 7: 3*d and 3*q in Q30
    assign d3_next[0] = (D3W'(p_ca_reg) <<< 15)
                      + D3W'(p_sb_reg) * D3W'($signed({1'b0, tpcd_pkg::SQRT3_Q15}));
    assign d3_next[1] = D3W'(p_cb_reg) * D3W'($signed({1'b0, tpcd_pkg::SQRT3_Q15}))
                      - (D3W'(p_sa_reg) <<< 15);

    always_ff @(posedge clk)
    begin
        if (load[tpcd_pkg::ST_SUM])
        begin
            d3_reg[0] <= d3_next[0];
            d3_reg[1] <= d3_next[1];
        end
    end

    // Stage 8: magnitude, add half divisor, drop 30 bits, clamp
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            mag[l]    = d3_reg[l][D3W-1] ? D3W'(-d3_reg[l]) : D3W'(d3_reg[l]);
            biased[l] = (D3W+1)'(mag[l]) + (D3W+1)'(tpcd_pkg::ROUND_BIAS);
            m_val[l]  = biased[l][D3W:30];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[tpcd_pkg::ST_ROUND])
        begin
            for (int l = 0; l < 2; l++)
            begin
                neg_reg[l] <= d3_reg[l][D3W-1];
                if (m_val[l] >= MW'(tpcd_pkg::M_CLAMP))
                    mcl_reg[l] <= tpcd_pkg::M_CLAMP;
                else
                    mcl_reg[l] <= m_val[l][14:0];
            end
        end
    end

    // Stage 9: divide by 3 through the reciprocal, restore sign, saturate
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            rq_prod[l] = 32'(mcl_reg[l]) * 32'(tpcd_pkg::DIV3_RECIP);
            rq[l]      = rq_prod[l][tpcd_pkg::DIV3_SHIFT +: tpcd_pkg::DQ_W];
            if (neg_reg[l])
                dq_next[l] = -$signed(rq[l]);
            else if (rq[l] > tpcd_pkg::DQ_MAX)
                dq_next[l] = $signed(tpcd_pkg::DQ_MAX);
            else
                dq_next[l] = $signed(rq[l]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[tpcd_pkg::ST_OUT])
        begin
            for (int l = 0; l < 2; l++)
            begin
                dq_reg[l]   <= dq_next[l];
                neg2_reg[l] <= neg_reg[l];
            end
        end
    end

    assign pa_out     = pa_d_reg[PH_DLY-1];
    assign pb_out     = pb_d_reg[PH_DLY-1];
    assign pc_out     = pc_d_reg[PH_DLY-1];
    // a negative d/q result must not read positive
    assign direct     = (neg2_reg[0] && dq_reg[0] > 0) ? -dq_reg[0] : dq_reg[0];
    assign quadrature = (neg2_reg[1] && dq_reg[1] > 0) ? -dq_reg[1] : dq_reg[1];

endmodule

// ----- design/three_phase_current_to_dq_core.sv -----
// Top level: three-phase current to d/q transform, nine-stage pipeline
//
// Usage:
//   samples  - input items: three raw phase ADC codes and the mechanical angle.
//   currents - result items: phase currents minus midpoint (saturated to 13 bits)
//              and the amplitude-invariant d/q currents (saturated to 14 bits).
//   cfg      - register writes: index 0 sets the ADC midpoint, index 1 the pole
//              pairs; other indexes are ignored. cfg.ready is always high.
//              Write registers only while no item is in flight.
// Stages: diff, mix, poly_t, poly_u, poly_s, prod, sum, round and out; an item
//   passes through them in that order before its result shows on currents.
// Throughput: one item per cycle unless currents stalls; every stage has its
//   own valid bit, and the four chained sine polynomial multiplies plus the
//   product, sum and divide-by-three stages of the projection set the depth.
// Reset (rst_n low, asynchronous): the pipeline empties, the midpoint returns
//   to half scale and the pole pairs to 7.
// Stall: while currents.ready is low the result is held; earlier stages keep
//   filling bubbles, so samples.ready drops only once every stage is full.
module three_phase_current_to_dq_core #(
    parameter int ADC_BITS   = tpcd_pkg::ADC_BITS_DEF,
    parameter int ANGLE_BITS = tpcd_pkg::ANGLE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tpcd_in_if.sink     samples,
    tpcd_out_if.source  currents,
    tpcd_cfg_if.sink    cfg
);

    logic [ADC_BITS-1:0]               midpoint_reg;
    logic [tpcd_pkg::POLE_W-1:0]       pole_pairs_reg;
    logic [tpcd_pkg::STAGES:1]         load;

    logic [16:0]                       x_sin, x_cos;
    logic [1:0]                        quad;
    logic signed [ADC_BITS+2:0]        asum;
    logic signed [ADC_BITS+1:0]        bmc;
    logic signed [tpcd_pkg::PHASE_W-1:0] pa, pb, pc;
    logic [14:0]                       sin_q, cos_q;

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            midpoint_reg   <= {1'b1, {(ADC_BITS-1){1'b0}}};
            pole_pairs_reg <= tpcd_pkg::POLE_PAIRS_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                tpcd_pkg::REG_ADC_MIDPOINT: midpoint_reg   <= cfg.data[ADC_BITS-1:0];
                tpcd_pkg::REG_POLE_PAIRS:   pole_pairs_reg <= cfg.data[tpcd_pkg::POLE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Handshake and stage enables
    tpcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (currents.valid),
        .out_ready (currents.ready),
        .load      (load)
    );

    // Midpoint removal, angle, Clarke sums
    tpcd_front #(
        .ADC_BITS   (ADC_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_front (
        .clk        (clk),
        .load       (load),
        .sample_a   (samples.sample_a),
        .sample_b   (samples.sample_b),
        .sample_c   (samples.sample_c),
        .mech_angle (samples.mech_angle),
        .midpoint   (midpoint_reg),
        .pole_pairs (pole_pairs_reg),
        .x_sin      (x_sin),
        .x_cos      (x_cos),
        .quad       (quad),
        .asum       (asum),
        .bmc        (bmc),
        .pa         (pa),
        .pb         (pb),
        .pc         (pc)
    );

    // Sine of the quadrant fraction and of its complement
    tpcd_qsine u_sine (
        .clk  (clk),
        .load (load),
        .x    (x_sin),
        .sine (sin_q)
    );

    tpcd_qsine u_cosine (
        .clk  (clk),
        .load (load),
        .x    (x_cos),
        .sine (cos_q)
    );

    // Park projection and output register
    tpcd_proj #(
        .ADC_BITS (ADC_BITS)
    ) u_proj (
        .clk        (clk),
        .load       (load),
        .quad       (quad),
        .asum       (asum),
        .bmc        (bmc),
        .pa         (pa),
        .pb         (pb),
        .pc         (pc),
        .sin_q      (sin_q),
        .cos_q      (cos_q),
        .pa_out     (currents.phase_a_amps),
        .pb_out     (currents.phase_b_amps),
        .pc_out     (currents.phase_c_amps),
        .direct     (currents.direct_amps),
        .quadrature (currents.quadrature_amps)
    );

endmodule

// ----- dv/tpcd_dq_checker.sv -----
// Checker for the current to d/q block: predicts each result and compares it
module tpcd_dq_checker (
    input  logic  clk,
    input  logic  rst_n,
    tpcd_in_if    samples,
    tpcd_out_if   currents,
    tpcd_cfg_if   cfg,
    output int    fails,
    output int    pending,
    output int    items_seen,
    output int    results_seen
);

    localparam int ADC_BITS_DEF   = tpcd_pkg::ADC_BITS_DEF;
    localparam int ANGLE_BITS_DEF = tpcd_pkg::ANGLE_BITS_DEF;
    localparam int PHASE_W        = tpcd_pkg::PHASE_W;
    localparam int DQ_W           = tpcd_pkg::DQ_W;
    localparam int POLE_W         = tpcd_pkg::POLE_W;

    localparam longint DQ_HI = 8191;
    localparam longint DQ_LO = -8192;

    typedef struct packed {
        logic signed [PHASE_W-1:0] phase_a;
        logic signed [PHASE_W-1:0] phase_b;
        logic signed [PHASE_W-1:0] phase_c;
        logic signed [DQ_W-1:0]    direct;
        logic signed [DQ_W-1:0]    quadrature;
    } dq_result_t;

    dq_result_t              expected_currents[$];
    dq_result_t              got;
    dq_result_t              want;
    logic [ADC_BITS_DEF-1:0] midpoint;
    logic [POLE_W-1:0]       pole_pairs;

    // Quarter-wave sine: x in Q0.16, result Q1.15
    function automatic int quarter_sine(input longint unsigned x);
        longint unsigned x2, t, u, s, r;
        x2 = (x * x) >> 16;
        t  = 64'(tpcd_pkg::POLY_B) - ((64'(tpcd_pkg::POLY_C) * x2) >> 16);
        u  = 64'(tpcd_pkg::POLY_A) - ((x2 * t) >> 16);
        s  = (x * u) >> 16;
        r  = (s + 64'd1) >> 1;
        if (r > 64'(tpcd_pkg::SINE_MAX))
            r = 64'(tpcd_pkg::SINE_MAX);
        return int'(r);
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Divide a Q30 triple by 3 * 2^30, nearest, ties away from zero
    function automatic longint round_third_q30(input longint num);
        longint unsigned den, mag, r;
        den = 64'd3 << 30;
        mag = (num < 0) ? 64'd0 - 64'(num) : 64'(num);
        r   = (mag + den / 2) / den;
        return (num < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic dq_result_t predict_currents(
        input logic [ADC_BITS_DEF-1:0]   sa,
        input logic [ADC_BITS_DEF-1:0]   sb,
        input logic [ADC_BITS_DEF-1:0]   sc,
        input logic [ANGLE_BITS_DEF-1:0] ang,
        input logic [ADC_BITS_DEF-1:0]   mid,
        input logic [POLE_W-1:0]         poles
    );
        dq_result_t                      res;
        longint                          a, b, c, alpha3, beta3, d3, q3;
        logic [ANGLE_BITS_DEF+POLE_W-1:0] turns;
        logic [ANGLE_BITS_DEF-1:0]       elec;
        longint unsigned                 x;
        int                              s_frac, s_comp, sn, cs;
        a = longint'(sa) - longint'(mid);
        b = longint'(sb) - longint'(mid);
        c = longint'(sc) - longint'(mid);

        // electrical angle wraps to one turn; zero pole pairs pins it at zero
        turns = ang * poles;
        elec  = turns[ANGLE_BITS_DEF-1:0];
        x = 64'(elec[ANGLE_BITS_DEF-3:0]) << (18 - ANGLE_BITS_DEF);
        s_frac = quarter_sine(x);
        s_comp = quarter_sine(64'(tpcd_pkg::QS_ONE) - x);
        case (elec[ANGLE_BITS_DEF-1 -: 2])
            tpcd_pkg::QUAD_0:
            begin
                sn = s_frac;
                cs = s_comp;
            end
            tpcd_pkg::QUAD_1:
            begin
                sn = s_comp;
                cs = -s_frac;
            end
            tpcd_pkg::QUAD_2:
            begin
                sn = -s_frac;
                cs = -s_comp;
            end
            default:
            begin
                sn = -s_comp;
                cs = s_frac;
            end
        endcase

        // Clarke then Park, all scaled by three
        alpha3 = (2 * a - b - c) * 32768;
        beta3  = (b - c) * longint'(tpcd_pkg::SQRT3_Q15);
        d3 = longint'(cs) * alpha3 + longint'(sn) * beta3;
        q3 = longint'(cs) * beta3 - longint'(sn) * alpha3;

        res.phase_a    = PHASE_W'(clamp(a, longint'(tpcd_pkg::PHASE_MIN),
                                        longint'(tpcd_pkg::PHASE_MAX)));
        res.phase_b    = PHASE_W'(clamp(b, longint'(tpcd_pkg::PHASE_MIN),
                                        longint'(tpcd_pkg::PHASE_MAX)));
        res.phase_c    = PHASE_W'(clamp(c, longint'(tpcd_pkg::PHASE_MIN),
                                        longint'(tpcd_pkg::PHASE_MAX)));
        res.direct     = DQ_W'(clamp(round_third_q30(d3), DQ_LO, DQ_HI));
        res.quadrature = DQ_W'(clamp(round_third_q30(q3), DQ_LO, DQ_HI));
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        fails++;
    endtask

    task automatic compare_field(input string name, input logic signed [63:0] g,
                                 input logic signed [63:0] w);
        if (g !== w)
            report_mismatch($sformatf("%s of result %0d: got %0d, expected %0d",
                                      name, results_seen, g, w));
    endtask

    // Track registers, predict on every accepted item, check every result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_currents.delete();
            midpoint     = {1'b1, {(ADC_BITS_DEF-1){1'b0}}};
            pole_pairs   = tpcd_pkg::POLE_PAIRS_RESET;
            fails        = 0;
            pending      = 0;
            items_seen   = 0;
            results_seen = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    tpcd_pkg::REG_ADC_MIDPOINT: midpoint   = cfg.data[ADC_BITS_DEF-1:0];
                    tpcd_pkg::REG_POLE_PAIRS:   pole_pairs = cfg.data[POLE_W-1:0];
                    default:                    ;
                endcase
            end
            if (samples.valid && samples.ready)
            begin
                expected_currents.push_back(predict_currents(samples.sample_a,
                    samples.sample_b, samples.sample_c, samples.mech_angle,
                    midpoint, pole_pairs));
                items_seen++;
            end
            if (currents.valid && currents.ready)
            begin
                got.phase_a    = currents.phase_a_amps;
                got.phase_b    = currents.phase_b_amps;
                got.phase_c    = currents.phase_c_amps;
                got.direct     = currents.direct_amps;
                got.quadrature = currents.quadrature_amps;
                if (expected_currents.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              results_seen));
                else
                begin
                    want = expected_currents.pop_front();
                    compare_field("phase_a_amps", got.phase_a, want.phase_a);
                    compare_field("phase_b_amps", got.phase_b, want.phase_b);
                    compare_field("phase_c_amps", got.phase_c, want.phase_c);
                    compare_field("direct_amps", got.direct, want.direct);
                    compare_field("quadrature_amps", got.quadrature, want.quadrature);
                end
                results_seen++;
            end
            pending = expected_currents.size();
        end
    end

endmodule

// ----- dv/testbench.sv -----
// Testbench top: drives samples and register writes, stalls results, gives the verdict
module testbench;

    // indexes the block decodes to nothing
    localparam logic [tpcd_pkg::CFG_ADDR_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [tpcd_pkg::CFG_ADDR_W-1:0] REG_SPARE_3 = 2'd3;

    logic clk;
    logic rst_n;
    int   sender_idle_pct = 0;
    int   recv_stall_pct  = 0;
    int   reg_writes      = 0;
    int   chk_fails, chk_pending, chk_items, chk_results;

    tpcd_in_if  samples_if ();
    tpcd_out_if currents_if ();
    tpcd_cfg_if cfg_if ();

    three_phase_current_to_dq_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples_if),
        .currents (currents_if),
        .cfg      (cfg_if)
    );

    tpcd_dq_checker u_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .samples      (samples_if),
        .currents     (currents_if),
        .cfg          (cfg_if),
        .fails        (chk_fails),
        .pending      (chk_pending),
        .items_seen   (chk_items),
        .results_seen (chk_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #400000;
        $display("FAILURE");
        $finish;
    end

    // result side: random back-pressure
    initial
    begin
        currents_if.ready = 1'b1;
        forever
        begin
            @(negedge clk);
            currents_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Mostly uniform codes, with the rails now and then
    function automatic logic [11:0] rand_code();
        case ($urandom_range(7))
            0:       return 12'h000;
            1:       return 12'hFFF;
            default: return 12'($urandom_range(4095));
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_sample(input logic [11:0] a, input logic [11:0] b,
                               input logic [11:0] c, input logic [11:0] ang);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            samples_if.valid <= 1'b0;
            @(negedge clk);
        end
        samples_if.valid      <= 1'b1;
        samples_if.sample_a   <= a;
        samples_if.sample_b   <= b;
        samples_if.sample_c   <= c;
        samples_if.mech_angle <= ang;
        do @(posedge clk); while (!samples_if.ready);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [tpcd_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [tpcd_pkg::CFG_DATA_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge clk); while (!cfg_if.ready);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
        @(negedge clk);
        reg_writes++;
    endtask

    // Stop sending and wait until every expected result is back
    task automatic wait_drained();
        samples_if.valid <= 1'b0;
        do @(negedge clk); while (chk_pending != 0);
    endtask

    task automatic run_random(input int count, input int idle_pct, input int stall_pct,
                              input bit pause_mid);
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        for (int i = 0; i < count; i++)
        begin
            if (pause_mid && i == count / 2)
                wait_drained();
            send_sample(rand_code(), rand_code(), rand_code(), rand_code());
        end
        wait_drained();
    endtask

    // Main stimulus
    initial
    begin
        rst_n                 = 1'b0;
        samples_if.valid      = 1'b0;
        samples_if.sample_a   = '0;
        samples_if.sample_b   = '0;
        samples_if.sample_c   = '0;
        samples_if.mech_angle = '0;
        cfg_if.valid          = 1'b0;
        cfg_if.index          = '0;
        cfg_if.data           = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: rails, balanced and unbalanced phases
        send_sample(12'h000, 12'h000, 12'h000, 12'h000);
        send_sample(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        send_sample(12'hFFF, 12'h000, 12'h000, 12'h000);
        send_sample(12'h000, 12'hFFF, 12'hFFF, 12'h800);
        send_sample(12'h800, 12'h800, 12'h800, 12'h001);
        send_sample(12'h001, 12'h002, 12'h003, 12'hAAA);
        wait_drained();

        // one pole pair, zero midpoint: walk the quadrant edges
        write_reg(tpcd_pkg::REG_ADC_MIDPOINT, 16'h0000);
        write_reg(tpcd_pkg::REG_POLE_PAIRS, 16'h0001);
        send_sample(12'hFFF, 12'h000, 12'h000, 12'h000);
        send_sample(12'hFFF, 12'h000, 12'h000, 12'h3FF);
        send_sample(12'hFFF, 12'h000, 12'h000, 12'h400);
        send_sample(12'hFFF, 12'h000, 12'h000, 12'h800);
        send_sample(12'hFFF, 12'h000, 12'h000, 12'hC00);
        send_sample(12'hFFF, 12'h000, 12'h000, 12'hFFF);
        send_sample(12'h000, 12'hFFF, 12'h000, 12'h200);
        wait_drained();

        // zero pole pairs keep the electrical angle at zero; top midpoint
        write_reg(tpcd_pkg::REG_ADC_MIDPOINT, 16'h0FFF);
        write_reg(tpcd_pkg::REG_POLE_PAIRS, 16'h0000);
        send_sample(12'h000, 12'h000, 12'h000, 12'h4D2);
        send_sample(12'hFFF, 12'h000, 12'hFFF, 12'hFA0);
        wait_drained();

        // upper data bits are dropped; 127 pole pairs still wrap
        write_reg(tpcd_pkg::REG_POLE_PAIRS, 16'hFFFF);
        write_reg(tpcd_pkg::REG_ADC_MIDPOINT, 16'hF7FF);
        send_sample(12'hABC, 12'h123, 12'h789, 12'hFFF);
        send_sample(12'h555, 12'hAAA, 12'h000, 12'h7FF);
        wait_drained();

        // unknown indexes must leave both registers alone
        write_reg(REG_SPARE_2, 16'h0123);
        write_reg(REG_SPARE_3, 16'hFFFF);
        send_sample(12'h555, 12'hAAA, 12'h123, 12'hFFF);
        wait_drained();

        write_reg(tpcd_pkg::REG_POLE_PAIRS, 16'd64);
        write_reg(tpcd_pkg::REG_ADC_MIDPOINT, 16'd2048);
        send_sample(12'hFFF, 12'h800, 12'h000, 12'h0FF);
        wait_drained();

        // random phases, each under its own settings and stall mix
        write_reg(tpcd_pkg::REG_ADC_MIDPOINT, {4'($urandom), 12'h000});
        write_reg(tpcd_pkg::REG_POLE_PAIRS, {9'($urandom), 7'd64});
        run_random(185, 0, 0, 1'b0);

        write_reg(tpcd_pkg::REG_ADC_MIDPOINT, {4'($urandom), 12'hFFF});
        write_reg(tpcd_pkg::REG_POLE_PAIRS, {9'($urandom), 7'd1});
        run_random(185, 58, 0, 1'b0);

        write_reg(tpcd_pkg::REG_ADC_MIDPOINT, 16'($urandom));
        write_reg(tpcd_pkg::REG_POLE_PAIRS, 16'($urandom));
        run_random(185, 0, 58, 1'b1);

        write_reg(REG_SPARE_2, 16'($urandom));
        write_reg(tpcd_pkg::REG_ADC_MIDPOINT, 16'($urandom));
        write_reg(tpcd_pkg::REG_POLE_PAIRS, {9'($urandom), 7'($urandom_range(64, 1))});
        run_random(185, 25, 25, 1'b0);

        // drain the pipeline once more past its depth
        recv_stall_pct = 0;
        repeat (2 * tpcd_pkg::STAGES) @(negedge clk);

        $display("Covered %0d sample items and %0d results under %0d register writes,",
                 chk_items, chk_results, reg_writes);
        $display("with pole pairs from 0 to 127, midpoint rails, and four stall mixes.");
        if (chk_fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
